/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers clocked on aclk, reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds whenever the block is out of reset: antecedent implies consequent
// in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mwr_pkg.sv */
// ----------------------------------------------------------------------------
// Microwire word reader package
// Phase encoding, sequencer state record and pin level record.
// ----------------------------------------------------------------------------
package mwr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_GAP     = 4'd1,
        PH_CMD_LO  = 4'd2,
        PH_CMD_HI  = 4'd3,
        PH_ADDR_LO = 4'd4,
        PH_ADDR_HI = 4'd5,
        PH_DATA_HI = 4'd6,
        PH_DATA_LO = 4'd7
    } mwr_phase_t;

    // Start bit and READ opcode, indexed by the command bit counter (2..0).
    localparam logic [3:0] READ_CMD  = 4'b0110;
    localparam logic [3:0] WIDTH_CAP = 4'd15;
    // Address bits beyond the 8-bit latched address are sent as zero.
    localparam logic [4:0] ADDR_BITS = 5'd8;

    typedef struct packed {
        mwr_phase_t  phase;
        logic [4:0]  bit_index;
        logic [7:0]  tick_div;
        logic [15:0] shift_word;
        logic [3:0]  learned_width;
        logic [7:0]  latched_addr;
        logic        detect_pass;
        logic        width_error;
    } mwr_state_t;

    typedef struct packed {
        logic cs;
        logic sk;
        logic di;
    } mwr_pins_t;

endpackage

/* hw/rtl/mwr_seq.sv */
// ----------------------------------------------------------------------------
// Microwire word reader sequencer
// Holds the read state and works out its next value for one tick.
// ----------------------------------------------------------------------------
module mwr_seq #(
    parameter int MAX_ADDRESS_BITS = 8,
    parameter int DATA_BITS        = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              start_req,
    input  logic [7:0]        word_address,
    input  logic              eeprom_data_out,
    input  logic [7:0]        half_period,
    output mwr_pkg::mwr_state_t state_next,
    output logic              done_next
);
    import mwr_pkg::*;

    localparam logic [4:0] MAX_BITS   = 5'(MAX_ADDRESS_BITS);
    localparam logic [3:0] MAX_CLAMP  = (MAX_ADDRESS_BITS > 15) ? 4'd15 : 4'(MAX_ADDRESS_BITS);
    localparam logic [4:0] DATA_FIRST = 5'(DATA_BITS - 1);

    mwr_state_t  state_reg;
    logic [7:0]  hp;
    logic [8:0]  div_inc;
    logic [5:0]  width_diff;
    logic [3:0]  width_seen;
    logic [3:0]  addr_size;

    always_comb begin
        hp         = (half_period == 8'd0) ? 8'd1 : half_period;
        div_inc    = {1'b0, state_reg.tick_div} + 9'd1;
        width_diff = {1'b0, MAX_BITS} - {1'b0, state_reg.bit_index};
        width_seen = (width_diff > 6'(WIDTH_CAP)) ? WIDTH_CAP : width_diff[3:0];
        addr_size  = (state_reg.learned_width == 4'd0) ? MAX_CLAMP
                                                       : state_reg.learned_width;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        if (state_reg.phase == PH_IDLE) begin
            if (start_req) begin
                state_next.latched_addr = word_address;
                state_next.detect_pass  = (state_reg.learned_width == 4'd0);
                state_next.phase        = PH_CMD_LO;
                state_next.bit_index    = 5'd2;
                state_next.tick_div     = 8'd0;
            end
        end else if (div_inc >= {1'b0, hp}) begin
            state_next.tick_div = 8'd0;
            unique case (state_reg.phase)
                PH_GAP: begin
                    state_next.phase     = PH_CMD_LO;
                    state_next.bit_index = 5'd2;
                end
                PH_CMD_LO: begin
                    state_next.phase = PH_CMD_HI;
                end
                PH_CMD_HI: begin
                    if (state_reg.bit_index == 5'd0) begin
                        state_next.phase     = PH_ADDR_LO;
                        state_next.bit_index = {1'b0, addr_size - 4'd1};
                    end else begin
                        state_next.bit_index = state_reg.bit_index - 5'd1;
                        state_next.phase     = PH_CMD_LO;
                    end
                end
                PH_ADDR_LO: begin
                    state_next.phase = PH_ADDR_HI;
                end
                PH_ADDR_HI: begin
                    if (!eeprom_data_out || state_reg.bit_index == 5'd0) begin
                        // The dummy zero ends the address phase; without it the
                        // full width is used and flagged during detection.
                        if (state_reg.detect_pass) begin
                            if (!eeprom_data_out) begin
                                state_next.learned_width = width_seen;
                            end else begin
                                state_next.learned_width = MAX_CLAMP;
                                state_next.width_error   = 1'b1;
                            end
                        end
                        state_next.phase      = PH_DATA_HI;
                        state_next.bit_index  = DATA_FIRST;
                        state_next.shift_word = 16'd0;
                    end else begin
                        state_next.bit_index = state_reg.bit_index - 5'd1;
                        state_next.phase     = PH_ADDR_LO;
                    end
                end
                PH_DATA_HI: begin
                    state_next.shift_word = {state_reg.shift_word[14:0], eeprom_data_out};
                    state_next.phase      = PH_DATA_LO;
                end
                PH_DATA_LO: begin
                    if (state_reg.bit_index != 5'd0) begin
                        state_next.bit_index = state_reg.bit_index - 5'd1;
                        state_next.phase     = PH_DATA_HI;
                    end else if (state_reg.detect_pass) begin
                        state_next.detect_pass = 1'b0;
                        state_next.phase       = PH_GAP;
                    end else begin
                        state_next.phase     = PH_IDLE;
                        state_next.bit_index = 5'd0;
                        done_next            = 1'b1;
                    end
                end
                default: begin
                    state_next.phase = PH_IDLE;
                end
            endcase
        end else begin
            state_next.tick_div = div_inc[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_IDLE, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/mwr_pins.sv */
// ----------------------------------------------------------------------------
// Microwire word reader pin decode
// Derives chip select, serial clock and data-in levels from a state.
// ----------------------------------------------------------------------------
module mwr_pins (
    input  mwr_pkg::mwr_state_t state,
    output mwr_pkg::mwr_pins_t  pins
);
    import mwr_pkg::*;

    always_comb begin
        pins = '0;
        unique case (state.phase) inside
            PH_CMD_LO, PH_CMD_HI: begin
                pins.cs = 1'b1;
                pins.sk = (state.phase == PH_CMD_HI);
                pins.di = READ_CMD[state.bit_index[1:0]];
            end
            PH_ADDR_LO, PH_ADDR_HI: begin
                pins.cs = 1'b1;
                pins.sk = (state.phase == PH_ADDR_HI);
                pins.di = (state.bit_index < ADDR_BITS) ?
                          state.latched_addr[state.bit_index[2:0]] : 1'b0;
            end
            PH_DATA_HI: begin
                pins.cs = 1'b1;
                pins.sk = 1'b1;
            end
            PH_DATA_LO: begin
                pins.cs = 1'b1;
            end
            default: begin
                pins = '0;
            end
        endcase
    end

endmodule

/* hw/rtl/microwire_eeprom_word_reader_top.sv */
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader
// Read master for small Microwire serial EEPROMs, advanced one tick per beat.
// ----------------------------------------------------------------------------
// Usage: every input beat on the s_ channel is one tick of serial timing. It
// carries a start request, the word address and the sampled EEPROM data-out
// level. Each accepted beat yields exactly one result beat on the m_ channel
// with the pin levels after that tick, busy/done status, the shifted word,
// the learned address width and the missing-dummy-zero flag.
// The result of a beat is in the output register on the cycle after
// acceptance. Throughput is one beat per cycle; the tick sequencer is a
// single registered pass, so a new beat is taken every cycle while results
// keep flowing.
// If the receiver stalls, the result waits in the output register and
// s_ready drops until it is taken; no tick is lost or repeated.
// The first read after reset detects the address width from the dummy zero
// and then repeats the read with that width. The cfg_wr_en/cfg_wr_data port
// sets the ticks per serial clock half period (zero acts as one).
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
// learned width and error flag, sets the half period to one tick and empties
// the output register.
// ----------------------------------------------------------------------------
module microwire_eeprom_word_reader_top #(
    parameter int MAX_ADDRESS_BITS = 8,
    parameter int DATA_BITS        = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Half period configuration
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Tick beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_req,
    input  logic [7:0]  s_word_address,
    input  logic        s_eeprom_data_out,
    // Result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_chip_select,
    output logic        m_serial_clock,
    output logic        m_serial_data_in,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [15:0] m_read_word,
    output logic [3:0]  m_address_width,
    output logic        m_no_dummy_zero
);
    import mwr_pkg::*;

    `include "assert_macros.svh"

    logic       half_period_reg;
    logic [7:0] half_ticks_reg;
    logic       accept;
    mwr_state_t state_next;
    logic       done_next;
    mwr_pins_t  pins_next;

    // Output register: taking a new beat is allowed whenever the held result
    // is empty or leaves in this same cycle.
    logic        m_valid_reg, m_valid_next;
    mwr_pins_t   pins_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [15:0] word_reg;
    logic [3:0]  width_reg;
    logic        nodz_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // The configuration register is written at once, with no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_ticks_reg  <= 8'd1;
            half_period_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            half_ticks_reg  <= cfg_wr_data;
            half_period_reg <= 1'b1;
        end
    end

    mwr_seq #(
        .MAX_ADDRESS_BITS(MAX_ADDRESS_BITS),
        .DATA_BITS       (DATA_BITS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (accept),
        .start_req      (s_start_req),
        .word_address   (s_word_address),
        .eeprom_data_out(s_eeprom_data_out),
        .half_period    (half_ticks_reg),
        .state_next     (state_next),
        .done_next      (done_next)
    );

    // Pin levels are decoded from the state after this tick.
    mwr_pins u_pins (
        .state(state_next),
        .pins (pins_next)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pins_reg  <= pins_next;
            busy_reg  <= (state_next.phase != PH_IDLE);
            done_reg  <= done_next;
            word_reg  <= state_next.shift_word;
            width_reg <= state_next.learned_width;
            nodz_reg  <= state_next.width_error;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_chip_select    = pins_reg.cs;
    assign m_serial_clock   = pins_reg.sk;
    assign m_serial_data_in = pins_reg.di;
    assign m_busy_res       = busy_reg;
    assign m_done_res       = done_reg;
    assign m_read_word      = word_reg;
    assign m_address_width  = width_reg;
    assign m_no_dummy_zero  = nodz_reg;

    // Every accepted tick must produce a held result on the next cycle.
    `ASSERT_NEXT(a_beat_gives_result, accept, m_valid, "accepted tick produced no result")
    // A finished word leaves the sequencer idle with chip select released.
    `ASSERT_SAME(a_done_is_idle, m_valid && m_done_res, !m_busy_res && !m_chip_select,
                 "done reported while still busy")
    // The serial clock only toggles while the device is selected.
    `ASSERT_SAME(a_clock_needs_cs, m_valid && m_serial_clock, m_chip_select,
                 "serial clock high without chip select")
    // An empty output register never blocks the input side.
    `ASSERT_SAME(a_empty_is_ready, !m_valid, s_ready, "input stalled with empty output")
    // Every configuration write is taken into the half period register.
    `ASSERT_NEXT(a_cfg_written, cfg_wr_en, half_period_reg && half_ticks_reg == $past(cfg_wr_data),
                 "half period write was lost")

endmodule
